### hw/rtl/dgs_pkg.sv
`default_nettype none

package dgs_pkg;

	// field widths
	localparam int unsigned CMD_W   = 2;
	localparam int unsigned TXG_W   = 6;
	localparam int unsigned RXG_W   = 5;
	localparam int unsigned CORR_W  = 8;
	localparam int unsigned SMP_W   = 12;
	localparam int unsigned LOSS_W  = 4;
	localparam int unsigned ACT_W   = 3;
	localparam int unsigned TXO_W   = 8;
	localparam int unsigned RL_W    = 3;
	localparam int unsigned POW_W   = 2 * SMP_W;
	localparam int unsigned IDX_W   = 3;
	localparam int unsigned CFG_W   = 12;
	localparam int unsigned S_DATA_W = 112;
	localparam int unsigned M_DATA_W = 16;

	// commands
	localparam logic [CMD_W-1:0] CMD_START = 2'd0;
	localparam logic [CMD_W-1:0] CMD_SYNC  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_LOSS  = 2'd2;

	// actions
	localparam logic [ACT_W-1:0] ACT_SYNC = 3'd0;
	localparam logic [ACT_W-1:0] ACT_LOSS = 3'd1;
	localparam logic [ACT_W-1:0] ACT_DONE = 3'd2;
	localparam logic [ACT_W-1:0] ACT_FAIL = 3'd3;
	localparam logic [ACT_W-1:0] ACT_BAD  = 3'd4;

	// register indexes
	localparam logic [IDX_W-1:0] REG_DC_LIMIT    = 3'd0;
	localparam logic [IDX_W-1:0] REG_CORR_MIN    = 3'd1;
	localparam logic [IDX_W-1:0] REG_TX_GAIN_MIN = 3'd2;
	localparam logic [IDX_W-1:0] REG_TX_GAIN_MAX = 3'd3;
	localparam logic [IDX_W-1:0] REG_ROUND_LIMIT = 3'd4;

	// register reset values
	localparam logic [SMP_W-1:0]  DC_LIMIT_RST    = 12'd200;
	localparam logic [CORR_W-1:0] CORR_MIN_RST    = 8'd130;
	localparam logic [TXG_W-1:0]  TX_GAIN_MIN_RST = 6'h2e;
	localparam logic [TXG_W-1:0]  TX_GAIN_MAX_RST = 6'h3f;
	localparam logic [RL_W-1:0]   ROUND_LIMIT_RST = 3'd6;

	// digital gain thresholds
	localparam logic [SMP_W-1:0] DG_T6  = 12'h783;
	localparam logic [SMP_W-1:0] DG_T3  = 12'h551;
	localparam logic [SMP_W-1:0] DG_T0  = 12'h3c4;
	localparam logic [SMP_W-1:0] DG_TM3 = 12'h2aa;
	localparam logic [SMP_W-1:0] DG_TM6 = 12'h1e3;
	localparam logic [SMP_W-1:0] DG_TM9 = 12'h156;
	localparam logic [SMP_W-1:0] DG_HI  = 12'd1922;
	localparam logic [SMP_W-1:0] DG_LO  = 12'd342;

	localparam logic [TXO_W-1:0] TX_FAIL_CODE = 8'hff;
	localparam logic [RXG_W-1:0] RX_GAIN_MAX  = 5'd31;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_SYNC,
		PH_LOSS
	} phase_t;

	// absolute value of a 12-bit two's complement word
	function automatic logic [SMP_W-1:0] mag12(input logic [SMP_W-1:0] v);
		logic [SMP_W-1:0] r;
		r = v[SMP_W-1] ? (~v + SMP_W'(1)) : v;
		return r;
	endfunction

	// rx gain step from the digital gain word
	function automatic logic signed [4:0] gain_step(input logic [SMP_W-1:0] d);
		logic signed [4:0] s;
		if (d >= DG_T6)       s = 5'sd6;
		else if (d >= DG_T3)  s = 5'sd3;
		else if (d >= DG_T0)  s = 5'sd0;
		else if (d >= DG_TM3) s = -5'sd3;
		else if (d >= DG_TM6) s = -5'sd6;
		else if (d >= DG_TM9) s = -5'sd9;
		else                  s = -5'sd12;
		return s;
	endfunction

	// clamp a signed tx gain candidate to lo..hi, low bound first
	function automatic logic [TXG_W-1:0] clamp_tx(input logic signed [7:0] v,
			input logic [TXG_W-1:0] lo, input logic [TXG_W-1:0] hi);
		logic [TXG_W-1:0] r;
		if (v < $signed({2'b00, lo}))      r = lo;
		else if (v > $signed({2'b00, hi})) r = hi;
		else                               r = v[TXG_W-1:0];
		return r;
	endfunction

endpackage

`default_nettype wire

### hw/rtl/dpk_gain_search_fsm.sv
`default_nettype none
// gain-search controller for PA predistortion calibration
//
// input stream (s_*): one beat per command. s_tuser carries the command
// (start, sync report, gain-loss report), s_tdata the measurement fields.
// output stream (m_*): exactly one result beat per input beat, in order.
// m_tuser carries the action, m_tdata the tx/rx gain codes and bypass flag.
// config port: cfg_we/cfg_index/cfg_data write one register per cycle;
// write only while no beat is in flight.
//
// pipeline: three register stages (input, precompute, result); a beat
// moves through them in order, held wherever the next stage is full.
// throughput: one beat per cycle while the sink is ready, set by the result
// stage that reads and updates the search state in the same cycle.
// precompute stage: dc magnitudes, gain step and the two power sums
// (two 12x12 squares each); the result stage does the power-ratio compare
// and the tx clamp.
// reset: search phase idle, gains and round count zero, registers at their
// defaults, all stages empty.
// sink stall: the result register holds; each stage keeps taking beats
// while the one after it has room, so up to three beats can be held.

module dpk_gain_search_fsm (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	// fields from bit 0: start_tx_gain, start_rx_gain, corr_value, dc_i_raw,
	// dc_q_raw, digital_gain, loss_index, first_i_raw, first_q_raw,
	// second_i_raw, second_q_raw, zero fill
	input  wire logic [dgs_pkg::S_DATA_W-1:0]   s_tdata,
	// fields from bit 0: command
	input  wire logic [dgs_pkg::CMD_W-1:0]      s_tuser,
	input  wire logic                           s_tvalid,
	output logic                                s_tready,
	// fields from bit 0: tx_gain, rx_gain, rx_filter_bypass, zero fill
	output logic [dgs_pkg::M_DATA_W-1:0]        m_tdata,
	// fields from bit 0: action
	output logic [dgs_pkg::ACT_W-1:0]           m_tuser,
	output logic                                m_tvalid,
	input  wire logic                           m_tready,
	input  wire logic                           cfg_we,
	input  wire logic [dgs_pkg::IDX_W-1:0]      cfg_index,
	input  wire logic [dgs_pkg::CFG_W-1:0]      cfg_data
);
	import dgs_pkg::*;

	// config registers
	logic [SMP_W-1:0]  dc_limit_q;
	logic [CORR_W-1:0] corr_min_q;
	logic [TXG_W-1:0]  tx_gain_min_q;
	logic [TXG_W-1:0]  tx_gain_max_q;
	logic [RL_W-1:0]   round_limit_q;

	// search state
	phase_t            phase_q, phase_d;
	logic [TXG_W-1:0]  tx_gain_q, tx_gain_d;
	logic [RXG_W-1:0]  rx_gain_q, rx_gain_d;
	logic              limited_q, limited_d;
	logic [RL_W-1:0]   round_q, round_d;

	// stage 1: registered input beat
	logic                  valid_s1;
	logic [CMD_W-1:0]      cmd_s1;
	logic [S_DATA_W-1:0]   data_s1;

	// stage 2: state-independent precompute
	logic                  valid_s2;
	logic [CMD_W-1:0]      cmd_s2;
	logic [TXG_W-1:0]      stx_s2;
	logic [RXG_W-1:0]      srx_s2;
	logic                  dc_fail_s2;
	logic signed [4:0]     step_s2;
	logic                  dg_oor_s2;
	logic [LOSS_W-1:0]     loss_s2;
	logic [POW_W-1:0]      pow_a_s2;
	logic [POW_W-1:0]      pow_b_s2;

	// result register
	logic                  out_valid_q;
	logic [ACT_W-1:0]      act_q;
	logic [TXO_W-1:0]      tx_out_q;
	logic [RXG_W-1:0]      rx_out_q;
	logic                  byp_q;

	// handshake between stages
	logic ready_out, ready_s2, ready_s1, fire_s2;

	assign ready_out = !out_valid_q || m_tready;
	assign ready_s2  = !valid_s2 || ready_out;
	assign ready_s1  = !valid_s1 || ready_s2;
	assign s_tready  = ready_s1;
	assign fire_s2   = valid_s2 && ready_out;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dc_limit_q    <= DC_LIMIT_RST;
			corr_min_q    <= CORR_MIN_RST;
			tx_gain_min_q <= TX_GAIN_MIN_RST;
			tx_gain_max_q <= TX_GAIN_MAX_RST;
			round_limit_q <= ROUND_LIMIT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_DC_LIMIT:    dc_limit_q    <= cfg_data[SMP_W-1:0];
				REG_CORR_MIN:    corr_min_q    <= cfg_data[CORR_W-1:0];
				REG_TX_GAIN_MIN: tx_gain_min_q <= cfg_data[TXG_W-1:0];
				REG_TX_GAIN_MAX: tx_gain_max_q <= cfg_data[TXG_W-1:0];
				REG_ROUND_LIMIT: round_limit_q <= cfg_data[RL_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// stage 1 capture
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ready_s1) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1 && s_tvalid) begin
			cmd_s1  <= s_tuser;
			data_s1 <= s_tdata;
		end
	end

	// unpack stage 1 fields
	logic [TXG_W-1:0]  stx_f;
	logic [RXG_W-1:0]  srx_f;
	logic [CORR_W-1:0] corr_f;
	logic [SMP_W-1:0]  dci_f, dcq_f, dg_f, fi_f, fq_f, si_f, sq_f;
	logic [LOSS_W-1:0] loss_f;

	assign stx_f  = data_s1[5:0];
	assign srx_f  = data_s1[10:6];
	assign corr_f = data_s1[18:11];
	assign dci_f  = data_s1[30:19];
	assign dcq_f  = data_s1[42:31];
	assign dg_f   = data_s1[54:43];
	assign loss_f = data_s1[58:55];
	assign fi_f   = data_s1[70:59];
	assign fq_f   = data_s1[82:71];
	assign si_f   = data_s1[94:83];
	assign sq_f   = data_s1[106:95];

	// magnitudes of the power-point samples, at most 2048 each
	logic [SMP_W-1:0] fi_m, fq_m, si_m, sq_m;
	assign fi_m = mag12(fi_f);
	assign fq_m = mag12(fq_f);
	assign si_m = mag12(si_f);
	assign sq_m = mag12(sq_f);

	// stage 2 capture
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ready_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s2 && valid_s1) begin
			cmd_s2     <= cmd_s1;
			stx_s2     <= stx_f;
			srx_s2     <= srx_f;
			dc_fail_s2 <= (mag12(dci_f) > dc_limit_q) || (mag12(dcq_f) > dc_limit_q)
				|| (corr_f < corr_min_q);
			step_s2    <= gain_step(dg_f);
			dg_oor_s2  <= (dg_f > DG_HI) || (dg_f < DG_LO);
			loss_s2    <= loss_f;
			// squares of values up to 2^11, their sum at most 2^23
			pow_a_s2   <= (fi_m * fi_m) + (fq_m * fq_m);
			pow_b_s2   <= (si_m * si_m) + (sq_m * sq_m);
		end
	end

	// command decode against the current phase
	logic is_start, is_sync, is_loss;
	assign is_start = (cmd_s2 == CMD_START);
	assign is_sync  = (cmd_s2 == CMD_SYNC) && (phase_q == PH_SYNC);
	assign is_loss  = (cmd_s2 == CMD_LOSS) && (phase_q == PH_LOSS);

	// power-ratio test: a >= floor(8b/5) is the same as 8b < 5a + 5
	logic [POW_W+2:0] pow_a5, pow_b8;
	logic             ratio_high;
	assign pow_a5     = ({3'b000, pow_a_s2} << 2) + {3'b000, pow_a_s2} + (POW_W+3)'(5);
	assign pow_b8     = {pow_b_s2, 3'b000};
	assign ratio_high = (pow_b8 < pow_a5);

	logic loss_high;
	assign loss_high = loss_s2[LOSS_W-1] || ((loss_s2 == '0) && ratio_high);

	// rx gain with the new step, -12..37 before the clamp
	logic signed [6:0] rx_sum;
	assign rx_sum = $signed({2'b00, rx_gain_q}) + $signed({{2{step_s2[4]}}, step_s2});

	// tx gain candidates
	logic signed [7:0] tx_s, tx_dn3, tx_up2, tx_dnl;
	assign tx_s   = $signed({2'b00, tx_gain_q});
	assign tx_dn3 = tx_s - 8'sd3;
	assign tx_up2 = tx_s + 8'sd2;
	assign tx_dnl = tx_s - $signed({4'b0000, loss_s2});

	// result and datapath update
	logic [ACT_W-1:0] act_d, act_pre;
	logic [TXO_W-1:0] tx_out_d;
	logic             byp_d;
	logic             end_req;

	always_comb begin
		tx_gain_d = tx_gain_q;
		rx_gain_d = rx_gain_q;
		limited_d = limited_q;
		round_d   = round_q;
		act_pre   = ACT_BAD;
		byp_d     = 1'b0;
		end_req   = 1'b0;
		priority if (is_start) begin
			tx_gain_d = stx_s2;
			rx_gain_d = srx_s2;
			limited_d = 1'b0;
			round_d   = '0;
			act_pre   = ACT_SYNC;
		end else if (is_sync) begin
			if (dc_fail_s2) begin
				act_pre = ACT_FAIL;
			end else if (limited_q) begin
				act_pre = ACT_LOSS;
			end else begin
				if (rx_sum > $signed({2'b00, RX_GAIN_MAX})) begin
					rx_gain_d = RX_GAIN_MAX;
					limited_d = 1'b1;
				end else if (rx_sum < 7'sd0) begin
					rx_gain_d = '0;
					limited_d = 1'b1;
				end else begin
					rx_gain_d = rx_sum[RXG_W-1:0];
				end
				byp_d   = (step_s2 != 5'sd0) || (round_q == '0);
				act_pre = dg_oor_s2 ? ACT_SYNC : ACT_LOSS;
				round_d = round_q + RL_W'(1);
			end
		end else if (is_loss) begin
			act_pre = ACT_LOSS;
			if (loss_high) begin
				if (tx_gain_q == tx_gain_min_q) begin
					end_req = 1'b1;
				end else begin
					tx_gain_d = clamp_tx(tx_dn3, tx_gain_min_q, tx_gain_max_q);
					round_d   = round_q + RL_W'(1);
				end
			end else if (loss_s2 == '0) begin
				if (tx_gain_q == tx_gain_max_q) begin
					end_req = 1'b1;
				end else begin
					tx_gain_d = clamp_tx(tx_up2, tx_gain_min_q, tx_gain_max_q);
					round_d   = round_q + RL_W'(1);
				end
			end else begin
				tx_gain_d = clamp_tx(tx_dnl, tx_gain_min_q, tx_gain_max_q);
				round_d   = round_q + RL_W'(1);
				end_req   = 1'b1;
			end
		end else begin
			act_pre = ACT_BAD;
		end

		// round limit and explicit end turn a request into done
		act_d = act_pre;
		if ((act_pre == ACT_SYNC) || (act_pre == ACT_LOSS)) begin
			if (end_req || (round_d >= round_limit_q)) begin
				act_d = ACT_DONE;
			end
		end

		tx_out_d = (act_d == ACT_FAIL) ? TX_FAIL_CODE : {2'b00, tx_gain_d};
	end

	// next phase follows from the action of the step
	always_comb begin
		unique case (act_d)
			ACT_SYNC: phase_d = PH_SYNC;
			ACT_LOSS: phase_d = PH_LOSS;
			ACT_DONE: phase_d = PH_IDLE;
			ACT_FAIL: phase_d = PH_IDLE;
			default:  phase_d = phase_q;
		endcase
	end

	// state update when the step leaves stage 2
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			tx_gain_q <= '0;
			rx_gain_q <= '0;
			limited_q <= 1'b0;
			round_q   <= '0;
		end else if (fire_s2) begin
			phase_q   <= phase_d;
			tx_gain_q <= tx_gain_d;
			rx_gain_q <= rx_gain_d;
			limited_q <= limited_d;
			round_q   <= round_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ready_out) begin
			out_valid_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s2) begin
			act_q    <= act_d;
			tx_out_q <= tx_out_d;
			rx_out_q <= rx_gain_d;
			byp_q    <= byp_d;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = act_q;
	assign m_tdata  = {2'b00, byp_q, rx_out_q, tx_out_q};

	// a failed search always reports the failure code
	a_fail_code: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (m_tuser == ACT_FAIL)) |-> (m_tdata[TXO_W-1:0] == TX_FAIL_CODE))
		else $error("failed result without failure tx code");

	// bypass only comes out of an rx gain adjustment
	a_bypass_act: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[TXO_W+RXG_W]) |->
		((m_tuser == ACT_SYNC) || (m_tuser == ACT_LOSS) || (m_tuser == ACT_DONE)))
		else $error("bypass set on a fail or unexpected-command result");

	// a step leaving stage 2 always lands in the result register
	a_stage_out: assert property (@(posedge clk) disable iff (!arst_n)
		fire_s2 |=> m_tvalid)
		else $error("step lost between stage 2 and result register");

endmodule

`default_nettype wire
